### rtl/dbwc_pkg.sv
// Shared types and constants for the delay-based window controller.
package dbwc_pkg;

   localparam int unsigned MSS_W   = 16;
   localparam int unsigned WBYTE_W = 28;
   localparam int unsigned DELAY_W = 20;
   localparam int unsigned TIME_W  = 48;
   localparam int unsigned CSR_W   = 28;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned ONE_Q16 = 65536;

   localparam logic [CSR_IDX_W-1:0] REG_SEGMENT_SIZE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_WINDOW      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_WINDOW      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_DELAY    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ADDITIVE_GAIN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DECREASE_GAIN   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DECREASE    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_RETRANSMIT_LIMIT = 3'd7;

   localparam logic OP_ACK  = 1'b0;
   localparam logic OP_NACK = 1'b1;

   typedef struct packed {
      logic                operation;
      logic [DELAY_W-1:0]  measured_delay;
      logic                congestion_marked;
      logic [TIME_W-1:0]   current_time;
   } req_payload_type;

   typedef struct packed {
      logic [WBYTE_W-1:0] window_bytes;
      logic               decrease_allowed;
      logic               window_reset;
   } rsp_payload_type;

endpackage

### rtl/dbwc_divider.sv
// Restoring bit-serial divider: one quotient bit per cycle.
module dbwc_divider #(
   parameter int unsigned NUM_W = 64,
   parameter int unsigned DEN_W = 44
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (start) begin
         q_in    = numer;
         r_in    = '0;
         d_in    = denom;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

### rtl/dbwc_multiplier.sv
// Shift-and-add serial multiplier: one multiplier bit per cycle.
module dbwc_multiplier #(
   parameter int unsigned A_W = 44,
   parameter int unsigned B_W = 17
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     op_a,
   input  logic [B_W-1:0]     op_b,
   output logic               done,
   output logic [A_W+B_W-1:0] prod
);
   localparam int unsigned CNT_W = $clog2(B_W + 1);

   logic [A_W+B_W-1:0] acc_ff, acc_in;
   logic [A_W+B_W-1:0] a_ff, a_in;
   logic [B_W-1:0]     b_ff, b_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = (A_W+B_W)'(op_a);
         b_in    = op_b;
         cnt_in  = CNT_W'(B_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = {a_ff[A_W+B_W-2:0], 1'b0};
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

### rtl/delay_based_window_controller_unit.sv
// The serial divider (one bit per cycle over 2F+24 numerator bits) followed by the 17-bit
// serial multiplier sets the long path; a loss scale uses the multiplier alone and an
// unchanged window goes straight to the finish step. One transaction at a time; the next
// request can be taken in the same cycle the result is raised when the receiver does not stall.
// A result waiting in the output register under stall blocks a new request.
// Reset (synchronous, active high) restores registers to defaults and window to 15000 bytes.
module delay_based_window_controller_unit #(
   parameter int unsigned WINDOW_FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  dbwc_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output dbwc_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write,
   input  logic [dbwc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dbwc_pkg::CSR_W-1:0] csr_data
);
   import dbwc_pkg::*;

   localparam int unsigned F     = WINDOW_FRACTION_BITS;
   localparam int unsigned WIN_W = WBYTE_W + F;
   // Numerator of growth: (ai*mss) << (2F-8), ai*mss is 32 bits.
   localparam int unsigned NUM_W = 32 + 2 * F - 8;
   localparam int unsigned DEN_W = (WIN_W > 37) ? WIN_W : 37;
   localparam int unsigned MUL_A = (WIN_W > NUM_W) ? WIN_W : NUM_W;
   localparam int unsigned MUL_B = 17;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_MUL, S_SCALE, S_FINISH
   } state_type;

   // Configuration registers.
   logic [MSS_W-1:0]   mss_ff;
   logic [WBYTE_W-1:0] min_ff, max_ff;
   logic [DELAY_W-1:0] target_ff;
   logic [15:0]        ai_ff;
   logic [16:0]        beta_ff, mdf_ff;
   logic [7:0]         limit_ff;

   // Controller state.
   logic [WIN_W-1:0]   win_ff, win_in, prev_ff;
   logic               may_ff, may_in;
   logic [TIME_W-1:0]  ldt_ff;
   logic [DELAY_W:0]   rtt_ff, rtt_in;
   logic [7:0]         cnt_ff, cnt_in;
   state_type          state_ff, state_in;
   req_payload_type    cur_ff, cur_in;
   logic               forced_ff, forced_in;
   logic               rv_ff;
   rsp_payload_type    rsp_ff;

   // Serial unit hookups.
   logic               div_start, div_done;
   logic [NUM_W-1:0]   div_num, div_q;
   logic [DEN_W-1:0]   div_den;
   logic               mul_start, mul_done;
   logic [MUL_A-1:0]   mul_a;
   logic [MUL_B-1:0]   mul_b;
   logic [MUL_A+MUL_B-1:0] mul_p;

   dbwc_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(div_num),
      .denom(div_den), .done(div_done), .quot(div_q)
   );

   dbwc_multiplier #(.A_W(MUL_A), .B_W(MUL_B)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .op_a(mul_a),
      .op_b(mul_b), .done(mul_done), .prod(mul_p)
   );

   // The input side is free when no transaction is in flight and no result is held up.
   logic accept;
   assign req_stall = (state_ff != S_IDLE) || (rv_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // Floor factor 1 - max_decrease, saturated at zero.
   logic [16:0] floor_fac;
   assign floor_fac = (mdf_ff >= 17'(ONE_Q16)) ? 17'd0 : 17'(ONE_Q16) - mdf_ff;

   logic [31:0]        gm;
   logic [WIN_W-1:0]   mss_q;
   logic [DELAY_W-1:0] excess;
   assign gm     = 32'(ai_ff) * 32'(mss_ff);
   assign mss_q  = WIN_W'(mss_ff) << F;
   assign excess = req_payload.measured_delay - target_ff;

   // Growth sum with a carry bit; a carry saturates, and the clamp then brings it to max.
   logic [WIN_W:0] grow_sum;
   assign grow_sum = {1'b0, win_ff} + {1'b0, WIN_W'(mul_p)};

   // Clamp for the common tail.
   logic [WIN_W-1:0]  lo_q, hi_q, clamped;
   assign lo_q    = WIN_W'(min_ff) << F;
   assign hi_q    = WIN_W'(max_ff) << F;
   assign clamped = (((win_ff < hi_q) ? win_ff : hi_q) < lo_q) ? lo_q
                  : ((win_ff < hi_q) ? win_ff : hi_q);

   // Tail values computed from the clamped window.
   logic             tail_le;
   logic [TIME_W-1:0] ldt_next, elapsed_next;
   assign tail_le      = clamped <= prev_ff;
   assign ldt_next     = tail_le ? cur_ff.current_time : ldt_ff;
   assign elapsed_next = cur_ff.current_time - ldt_next;

   logic [16:0]      a_fac;
   always_comb begin
      state_in  = state_ff;
      win_in    = win_ff;
      may_in    = may_ff;
      rtt_in    = rtt_ff;
      cnt_in    = cnt_ff;
      cur_in    = cur_ff;
      forced_in = forced_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      a_fac     = 17'(ONE_Q16);
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cur_in    = req_payload;
               forced_in = 1'b0;
               if (req_payload.operation == OP_ACK) begin
                  cnt_in = '0;
                  rtt_in = {req_payload.measured_delay, 1'b0};
                  if (req_payload.measured_delay < target_ff
                      || !req_payload.congestion_marked) begin
                     if (win_ff >= mss_q && win_ff != '0) begin
                        div_start = 1'b1;
                        div_num   = NUM_W'(gm) << (2 * F - 8);
                        div_den   = DEN_W'(win_ff);
                        state_in  = S_DIV;
                     end else begin
                        win_in   = win_ff + (WIN_W'(gm) << (F - 8));
                        state_in = S_FINISH;
                     end
                  end else if (may_ff) begin
                     if (req_payload.measured_delay != '0) begin
                        // Decrease term beta*excess/delay goes through the divider.
                        div_start = 1'b1;
                        div_num   = NUM_W'(40'(beta_ff) * 40'(excess));
                        div_den   = DEN_W'(req_payload.measured_delay);
                        state_in  = S_SCALE;
                     end else begin
                        state_in  = S_SCALE;
                        mul_start = 1'b1;
                        mul_a     = MUL_A'(win_ff);
                        mul_b     = 17'(ONE_Q16);
                     end
                  end else begin
                     state_in = S_FINISH;
                  end
               end else begin
                  may_in = (req_payload.current_time - ldt_ff) >= TIME_W'(rtt_ff);
                  cnt_in = (cnt_ff == 8'hFF) ? cnt_ff : cnt_ff + 8'd1;
                  if (((cnt_ff == 8'hFF) ? cnt_ff : cnt_ff + 8'd1) >= limit_ff) begin
                     win_in    = lo_q;
                     forced_in = 1'b1;
                     state_in  = S_FINISH;
                  end else if ((req_payload.current_time - ldt_ff)
                               >= TIME_W'(rtt_ff)) begin
                     mul_start = 1'b1;
                     mul_a     = MUL_A'(win_ff);
                     mul_b     = floor_fac;
                     state_in  = S_SCALE;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
            end
         end
         S_DIV: begin
            // Growth quotient times segment size.
            if (div_done) begin
               mul_start = 1'b1;
               mul_a     = MUL_A'(div_q);
               mul_b     = MUL_B'(mss_ff);
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               win_in   = grow_sum[WIN_W] ? '1 : grow_sum[WIN_W-1:0];
               state_in = S_FINISH;
            end
         end
         S_SCALE: begin
            if (div_done) begin
               a_fac = (div_q >= NUM_W'(ONE_Q16)) ? 17'd0
                     : 17'(ONE_Q16) - 17'(div_q);
               mul_start = 1'b1;
               mul_a     = MUL_A'(win_ff);
               mul_b     = (a_fac > floor_fac) ? a_fac : floor_fac;
            end else if (mul_done) begin
               win_in   = WIN_W'(mul_p >> 16);
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // Clamp, then an ack refreshes the decrease permission from the new timestamp.
            win_in = clamped;
            if (cur_ff.operation == OP_ACK) begin
               may_in = elapsed_next >= TIME_W'(rtt_ff);
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (reset) begin
         mss_ff    <= MSS_W'(1500);
         min_ff    <= WBYTE_W'(15000);
         max_ff    <= WBYTE_W'(150000000);
         target_ff <= DELAY_W'(1000);
         ai_ff     <= 16'd256;
         beta_ff   <= 17'd32768;
         mdf_ff    <= 17'd32768;
         limit_ff  <= 8'd10;
         win_ff    <= WIN_W'(15000) << F;
         prev_ff   <= WIN_W'(15000) << F;
         may_ff    <= 1'b1;
         ldt_ff    <= '0;
         rtt_ff    <= '0;
         cnt_ff    <= '0;
         state_ff  <= S_IDLE;
         forced_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_SEGMENT_SIZE:     mss_ff    <= csr_data[MSS_W-1:0];
               REG_MIN_WINDOW:       min_ff    <= csr_data[WBYTE_W-1:0];
               REG_MAX_WINDOW:       max_ff    <= csr_data[WBYTE_W-1:0];
               REG_TARGET_DELAY:     target_ff <= csr_data[DELAY_W-1:0];
               REG_ADDITIVE_GAIN:    ai_ff     <= csr_data[15:0];
               REG_DECREASE_GAIN:    beta_ff   <= csr_data[16:0];
               REG_MAX_DECREASE:     mdf_ff    <= csr_data[16:0];
               REG_RETRANSMIT_LIMIT: limit_ff  <= csr_data[7:0];
               default: ;
            endcase
         end
         state_ff  <= state_in;
         win_ff    <= win_in;
         may_ff    <= may_in;
         rtt_ff    <= rtt_in;
         cnt_ff    <= cnt_in;
         forced_ff <= forced_in;
         if (state_ff == S_FINISH) begin
            // Decrease timestamp, previous window, and result.
            prev_ff <= clamped;
            ldt_ff  <= ldt_next;
            rv_ff   <= 1'b1;
            rsp_ff.window_bytes     <= clamped[F +: WBYTE_W];
            rsp_ff.window_reset     <= forced_ff;
            rsp_ff.decrease_allowed <= may_in;
         end else if (rv_ff && !rsp_stall) begin
            rv_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rv_ff;
   assign rsp_payload = rsp_ff;

   // A new request is only taken while the sequencer is idle.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("request taken while busy");
   // An ack never reports a forced window reset.
   a_ack_no_reset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && cur_ff.operation == OP_ACK) |=> !rsp_ff.window_reset)
      else $error("ack reported window reset");
   // The finish step always raises a result.
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |=> rv_ff)
      else $error("finished transaction without result");
   // Retransmit count clears after an ack.
   a_ack_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.operation == OP_ACK) |=> (cnt_ff == '0))
      else $error("ack did not clear retransmit count");
endmodule

### tb/tb_top.sv
// Self-checking testbench for the delay-based window controller unit.
`timescale 1ns / 1ps

module tb_top;
   import dbwc_pkg::*;

   // Cycles without any accepted transaction before the run is declared hung.
   localparam int unsigned HANG_LIMIT = 20000;
   localparam int unsigned RANDOM_PER_PHASE = 90;
   localparam int unsigned SETTLE_CYCLES = 200;
   localparam int unsigned FRAC = 16;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   rsp_payload_type rsp_payload;
   logic csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_data;

   delay_based_window_controller_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Shadow copy of the configuration registers.
   logic [63:0] mss_r, min_r, max_r, target_r, ai_r, beta_r, maxdec_r, limit_r;
   // Shadow copy of the controller state; the window keeps FRAC fraction bits.
   logic [63:0] cwnd, prev_cwnd, last_dec_time, round_trip, rtx_count;
   logic may_dec;

   req_payload_type event_q[$];      // transactions still to be driven
   rsp_payload_type window_q[$];     // predicted results, oldest first
   int unsigned mismatches = 0;
   int unsigned send_idle = 0;       // percent of cycles the sender holds off
   int unsigned recv_idle = 0;       // percent of cycles the receiver stalls
   logic [47:0] clock_us = 48'd0;    // running event time for random traffic
   bit req_accepted = 1'b0;
   int unsigned quiet_cycles = 0;

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
      mismatches++;
   endtask

   // Elapsed time since the last decrease, wrapping in 48 bits, compared to a round trip.
   function automatic logic round_trip_elapsed(input logic [47:0] now, input logic [63:0] rt);
      logic [47:0] diff;
      diff = now - last_dec_time[47:0];
      return {16'd0, diff} >= rt;
   endfunction

   // Clamp to the window bounds (the minimum wins) and track the last decrease.
   function automatic void clamp_window(input logic [47:0] now);
      logic [63:0] lo, hi;
      lo = min_r << FRAC;
      hi = max_r << FRAC;
      if (cwnd > hi) cwnd = hi;
      if (cwnd < lo) cwnd = lo;
      if (cwnd <= prev_cwnd) last_dec_time = {16'd0, now};
      prev_cwnd = cwnd;
   endfunction

   // Advances the shadow state by one event and returns the window the block should report.
   function automatic rsp_payload_type predict_window(input req_payload_type ev);
      logic [63:0] delay, gm, inc, p, a, b, term;
      rsp_payload_type r;
      delay = {44'd0, ev.measured_delay};
      b = (maxdec_r >= 64'(ONE_Q16)) ? 64'd0 : 64'(ONE_Q16) - maxdec_r;
      r.window_reset = 1'b0;
      if (ev.operation == OP_ACK) begin
         rtx_count = 64'd0;
         round_trip = delay * 2;
         if (delay < target_r || !ev.congestion_marked) begin
            gm = ai_r * mss_r;
            if (cwnd >= (mss_r << FRAC)) begin
               if (cwnd == 0) begin
                  inc = 64'd0;
               end else begin
                  p = (gm << (2 * FRAC - 8)) / cwnd;
                  inc = p * mss_r;
               end
            end else begin
               inc = gm << (FRAC - 8);
            end
            cwnd = cwnd + inc;
         end else if (may_dec) begin
            a = 64'(ONE_Q16);
            if (delay != 0) begin
               term = (beta_r * (delay - target_r)) / delay;
               a = (term >= 64'(ONE_Q16)) ? 64'd0 : 64'(ONE_Q16) - term;
            end
            cwnd = (cwnd * ((a > b) ? a : b)) >> 16;
         end
         clamp_window(ev.current_time);
         may_dec = round_trip_elapsed(ev.current_time, round_trip);
      end else begin
         may_dec = round_trip_elapsed(ev.current_time, round_trip);
         if (rtx_count < 255) rtx_count++;
         if (rtx_count >= limit_r) begin
            cwnd = min_r << FRAC;
            r.window_reset = 1'b1;
         end else if (may_dec) begin
            cwnd = (cwnd * b) >> 16;
         end
         clamp_window(ev.current_time);
      end
      r.window_bytes = cwnd[FRAC +: WBYTE_W];
      r.decrease_allowed = may_dec;
      return r;
   endfunction

   // Register writes happen only while the block is idle, so the shadow copy is updated
   // right away.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      case (idx)
         REG_SEGMENT_SIZE: mss_r = value & 64'hFFFF;
         REG_MIN_WINDOW: min_r = value & 64'hFFF_FFFF;
         REG_MAX_WINDOW: max_r = value & 64'hFFF_FFFF;
         REG_TARGET_DELAY: target_r = value & 64'hF_FFFF;
         REG_ADDITIVE_GAIN: ai_r = value & 64'hFFFF;
         REG_DECREASE_GAIN: beta_r = value & 64'h1_FFFF;
         REG_MAX_DECREASE: maxdec_r = value & 64'h1_FFFF;
         default: limit_r = value & 64'hFF;
      endcase
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic write_all(input logic [CSR_W-1:0] mss, input logic [CSR_W-1:0] wmin,
                            input logic [CSR_W-1:0] wmax, input logic [CSR_W-1:0] tgt,
                            input logic [CSR_W-1:0] ai, input logic [CSR_W-1:0] beta,
                            input logic [CSR_W-1:0] mdec, input logic [CSR_W-1:0] lim);
      write_reg(REG_SEGMENT_SIZE, mss);
      write_reg(REG_MIN_WINDOW, wmin);
      write_reg(REG_MAX_WINDOW, wmax);
      write_reg(REG_TARGET_DELAY, tgt);
      write_reg(REG_ADDITIVE_GAIN, ai);
      write_reg(REG_DECREASE_GAIN, beta);
      write_reg(REG_MAX_DECREASE, mdec);
      write_reg(REG_RETRANSMIT_LIMIT, lim);
   endtask

   task automatic queue_event(input logic op, input logic [DELAY_W-1:0] delay,
                              input logic marked, input logic [TIME_W-1:0] now);
      req_payload_type ev;
      ev.operation = op;
      ev.measured_delay = delay;
      ev.congestion_marked = marked;
      ev.current_time = now;
      event_q.push_back(ev);
   endtask

   // Random traffic: mostly acknowledgements with delays near the target and time moving
   // forward, with some losses, wild delays and arbitrary timestamps mixed in.
   task automatic queue_random(input int unsigned count);
      logic op;
      logic [DELAY_W-1:0] delay;
      logic [63:0] span;
      for (int unsigned i = 0; i < count; i++) begin
         op = ($urandom_range(0, 3) == 0) ? OP_NACK : OP_ACK;
         span = 64'($urandom_range(1, 3000));
         if ($urandom_range(0, 7) == 0)
            delay = DELAY_W'($urandom);
         else if ($urandom_range(0, 1) == 0)
            delay = DELAY_W'(target_r + 64'($urandom_range(0, span)));
         else
            delay = (target_r > span) ? DELAY_W'(target_r - 64'($urandom_range(0, span)))
                                      : DELAY_W'($urandom_range(0, target_r));
         if ($urandom_range(0, 15) == 0)
            clock_us = TIME_W'({$urandom, $urandom});
         else
            clock_us = clock_us + TIME_W'($urandom_range(0, 4000));
         queue_event(op, delay, 1'($urandom_range(0, 1)), clock_us);
      end
   endtask

   // Lets the queue drain and every prediction come back, then some settle time.
   task automatic drain_phase();
      while (event_q.size() != 0 || req_valid || window_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Driver: presents one transaction at a time and holds it until it is accepted.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_accepted) begin
            if (event_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               req_payload <= event_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_idle);
      end
      req_accepted = 1'b0;
   end

   // Monitor: predicts on every accepted request and checks every accepted result.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            window_q.push_back(predict_window(req_payload));
            req_accepted = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (window_q.size() == 0) begin
               $display("result with no transaction outstanding at %0t", $realtime);
               mismatches++;
            end else begin
               want = window_q.pop_front();
               if (rsp_payload.window_bytes !== want.window_bytes)
                  report_mismatch("window_bytes", rsp_payload.window_bytes, want.window_bytes);
               if (rsp_payload.decrease_allowed !== want.decrease_allowed)
                  report_mismatch("decrease_allowed", rsp_payload.decrease_allowed,
                                  want.decrease_allowed);
               if (rsp_payload.window_reset !== want.window_reset)
                  report_mismatch("window_reset", rsp_payload.window_reset, want.window_reset);
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      mss_r = 1500;
      min_r = 15000;
      max_r = 150000000;
      target_r = 1000;
      ai_r = 256;
      beta_r = 32768;
      maxdec_r = 32768;
      limit_r = 10;
      cwnd = 64'd15000 << FRAC;
      prev_cwnd = cwnd;
      may_dec = 1'b1;
      last_dec_time = 0;
      round_trip = 0;
      rtx_count = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Reset defaults. Directed cases first: growth, delay-driven decrease, a marked high-delay
      // acknowledgement while no decrease is yet allowed, losses up to the retransmit limit, time going
      // backwards and a marked acknowledgement below the target.
      send_idle = 31;
      recv_idle = 55;
      queue_event(OP_ACK, 20'd0, 1'b0, 48'd0);
      queue_event(OP_ACK, 20'd2000, 1'b1, 48'd100);
      queue_event(OP_ACK, 20'hF_FFFF, 1'b1, 48'd5000000);
      for (int i = 0; i < 11; i++)
         queue_event(OP_NACK, DELAY_W'($urandom), 1'($urandom_range(0, 1)),
                     48'd5000000 + TIME_W'(i * 3000));
      queue_event(OP_ACK, 20'd900, 1'b1, 48'hFFFF_FFFF_FFFF);
      queue_event(OP_ACK, 20'd10, 1'b1, 48'd7);
      queue_random(RANDOM_PER_PHASE);
      drain_phase();

      // Upper extremes: huge segment puts the window below one segment, zero target makes
      // a zero delay take the decrease path, and a zero maximum decrease leaves a decrease without effect.
      write_all(65535, 0, 28'hFFF_FFFF, 0, 65535, 28'h1_FFFF, 0, 255);
      queue_event(OP_ACK, 20'd0, 1'b0, 48'd10);
      queue_event(OP_ACK, 20'd0, 1'b1, 48'd20);
      queue_event(OP_ACK, 20'd50, 1'b1, 48'd30);
      clock_us = 48'd100;
      queue_random(RANDOM_PER_PHASE);
      drain_phase();

      // Zero segment size, minimum above maximum, zero gains, full decrease, zero limit.
      send_idle = 55;
      recv_idle = 31;
      write_all(0, 200000, 100, 20'hF_FFFF, 0, 0, 28'h1_FFFF, 0);
      queue_event(OP_NACK, 20'd0, 1'b0, 48'd0);
      queue_event(OP_ACK, 20'hF_FFFF, 1'b1, 48'd1);
      queue_random(RANDOM_PER_PHASE);
      drain_phase();

      // Smallest nonzero settings; beta and the decrease fraction at exactly one.
      write_all(1, 1, 1000000, 500, 1000, 65536, 65536, 1);
      queue_random(RANDOM_PER_PHASE);
      drain_phase();

      // Moderate settings with no idling on either side.
      send_idle = 0;
      recv_idle = 0;
      write_all(9000, 0, 5000000, 20000, 512, 40000, 20000, 3);
      queue_random(RANDOM_PER_PHASE);
      drain_phase();

      // Random settings with a small retransmit limit so losses reach it.
      write_all(CSR_W'($urandom_range(1, 65535)), CSR_W'($urandom_range(0, 100000)),
                CSR_W'($urandom), CSR_W'($urandom_range(0, 5000)),
                CSR_W'($urandom_range(0, 65535)), CSR_W'($urandom_range(0, 131071)),
                CSR_W'($urandom_range(0, 131071)), CSR_W'($urandom_range(1, 6)));
      queue_random(RANDOM_PER_PHASE);
      drain_phase();

      if (mismatches == 0 && window_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
